// ===== rtl/hck_pkg.sv =====
// Shared types, key codes and decode functions for the hex calculator key engine.
// Used by the top level, the bit-serial arithmetic unit and the testbench; depends on nothing.
`default_nettype none

package hck_pkg;

    // Key codes that the engine treats specially.
    localparam logic [7:0] KEY_EQUALS    = 8'd61;
    localparam logic [7:0] KEY_BACKSPACE = 8'd8;
    localparam logic [7:0] KEY_CLEAR_RST = 8'd27;
    localparam logic [7:0] KEY_PLUS      = 8'd43;
    localparam logic [7:0] KEY_MINUS     = 8'd45;
    localparam logic [7:0] KEY_STAR      = 8'd42;
    localparam logic [7:0] KEY_AMP       = 8'd38;
    localparam logic [7:0] KEY_BAR       = 8'd124;
    localparam logic [7:0] KEY_CARET     = 8'd94;
    localparam logic [7:0] KEY_LESS      = 8'd60;
    localparam logic [7:0] KEY_GREATER   = 8'd62;
    localparam logic [7:0] KEY_SLASH     = 8'd47;
    localparam logic [7:0] KEY_PERCENT   = 8'd37;
    localparam logic [7:0] KEY_DIGIT_0   = 8'd48;
    localparam logic [7:0] KEY_DIGIT_9   = 8'd57;
    localparam logic [7:0] KEY_UPPER_A   = 8'd65;
    localparam logic [7:0] KEY_UPPER_F   = 8'd70;
    localparam logic [7:0] KEY_LOWER_A   = 8'd97;
    localparam logic [7:0] KEY_LOWER_F   = 8'd102;
    localparam logic [7:0] CASE_OFFSET   = 8'd32;

    // Operand width, also the number of bit steps the serial unit takes for one operation, and step counter width.
    localparam int unsigned DATA_W  = 32;
    localparam int unsigned CNT_W   = 5;

    // Operations of the serial arithmetic unit.
    typedef enum logic [3:0] {
        ALU_PASS,
        ALU_ADD,
        ALU_SUB,
        ALU_MUL,
        ALU_AND,
        ALU_OR,
        ALU_XOR,
        ALU_SHL,
        ALU_SHR,
        ALU_DIV,
        ALU_MOD,
        ALU_ZERO
    } alu_op_t;

    // Request from the key sequencer to the arithmetic unit.
    typedef struct packed {
        logic    start;
        alu_op_t op;
    } alu_req_t;

    // States of the key sequencer.
    typedef enum logic [1:0] {
        ST_IDLE,
        ST_CALC,
        ST_EMIT
    } state_t;

    // Lower-case a to f become upper case; everything else is left alone.
    function automatic logic [7:0] fold_key(input logic [7:0] key);
        logic [7:0] folded;
        folded = key;
        if (key >= KEY_LOWER_A && key <= KEY_LOWER_F)
        begin
            folded = key - CASE_OFFSET;
        end
        return folded;
    endfunction

    function automatic logic is_hex_key(input logic [7:0] key);
        return (key >= KEY_DIGIT_0 && key <= KEY_DIGIT_9) ||
               (key >= KEY_UPPER_A && key <= KEY_UPPER_F);
    endfunction

    // Digit value of a folded hex key; letters sit nine above their low nibble.
    function automatic logic [3:0] hex_digit(input logic [7:0] key);
        logic [3:0] digit;
        if (key <= KEY_DIGIT_9)
        begin
            digit = key[3:0];
        end
        else
        begin
            digit = key[3:0] + 4'd9;
        end
        return digit;
    endfunction

    // Operator keys map to unit operations; anything unknown yields zero.
    function automatic alu_op_t key_to_op(input logic [7:0] key);
        alu_op_t op;
        unique case (key)
            KEY_EQUALS:  op = ALU_PASS;
            KEY_PLUS:    op = ALU_ADD;
            KEY_MINUS:   op = ALU_SUB;
            KEY_STAR:    op = ALU_MUL;
            KEY_AMP:     op = ALU_AND;
            KEY_BAR:     op = ALU_OR;
            KEY_CARET:   op = ALU_XOR;
            KEY_LESS:    op = ALU_SHL;
            KEY_GREATER: op = ALU_SHR;
            KEY_SLASH:   op = ALU_DIV;
            KEY_PERCENT: op = ALU_MOD;
            default:     op = ALU_ZERO;
        endcase
        return op;
    endfunction

endpackage

`default_nettype wire

// ===== rtl/hck_alu.sv =====
// Bit-serial arithmetic unit of the hex calculator: one bit of the operands per cycle.
// Depends on hck_pkg for the operation codes and the request structure.
`default_nettype none

module hck_alu (
    input  wire logic                       clk,
    input  wire logic                       rst_n,
    input  wire hck_pkg::alu_req_t          req,
    input  wire logic [hck_pkg::DATA_W-1:0] opa,
    input  wire logic [hck_pkg::DATA_W-1:0] opb,
    output logic                            done,
    output logic [hck_pkg::DATA_W-1:0]      result
);
    import hck_pkg::*;

    alu_op_t           op_reg,    op_next;
    logic [DATA_W-1:0] a_reg,     a_next;
    logic [DATA_W-1:0] b_reg,     b_next;
    logic [DATA_W-1:0] acc_reg,   acc_next;
    logic              carry_reg, carry_next;
    logic [CNT_W-1:0]  cnt_reg,   cnt_next;
    logic              busy_reg,  busy_next;
    logic              fin_reg,   fin_next;

    logic              b_bit;
    logic              sum_bit;
    logic [DATA_W:0]   rem_shift;
    logic [DATA_W:0]   rem_diff;
    logic              b_zero;
    logic              shift_big;

    // Remainder trial for the restoring divider.
    assign rem_shift = {acc_reg, a_reg[DATA_W-1]};
    assign rem_diff  = rem_shift - {1'b0, b_reg};

    // Serial adder bit; subtraction adds the inverted bit with a carry in of one.
    assign b_bit   = (op_reg == ALU_SUB) ? ~b_reg[0] : b_reg[0];
    assign sum_bit = a_reg[0] ^ b_bit ^ carry_reg;

    assign b_zero    = (b_reg == '0);
    assign shift_big = (b_reg[DATA_W-1:CNT_W] != '0);

    // One step per cycle while busy.
    always_comb
    begin
        op_next    = op_reg;
        a_next     = a_reg;
        b_next     = b_reg;
        acc_next   = acc_reg;
        carry_next = carry_reg;
        cnt_next   = cnt_reg;
        busy_next  = busy_reg;
        fin_next   = 1'b0;
        if (req.start)
        begin
            op_next    = req.op;
            a_next     = opa;
            b_next     = opb;
            acc_next   = '0;
            carry_next = (req.op == ALU_SUB);
            cnt_next   = '0;
            busy_next  = 1'b1;
        end
        else if (busy_reg)
        begin
            unique case (op_reg)
                ALU_ADD, ALU_SUB:
                begin
                    acc_next   = {sum_bit, acc_reg[DATA_W-1:1]};
                    carry_next = (a_reg[0] & b_bit) | (carry_reg & (a_reg[0] ^ b_bit));
                    a_next     = a_reg >> 1;
                    b_next     = b_reg >> 1;
                end
                ALU_AND:
                begin
                    acc_next = {a_reg[0] & b_reg[0], acc_reg[DATA_W-1:1]};
                    a_next   = a_reg >> 1;
                    b_next   = b_reg >> 1;
                end
                ALU_OR:
                begin
                    acc_next = {a_reg[0] | b_reg[0], acc_reg[DATA_W-1:1]};
                    a_next   = a_reg >> 1;
                    b_next   = b_reg >> 1;
                end
                ALU_XOR:
                begin
                    acc_next = {a_reg[0] ^ b_reg[0], acc_reg[DATA_W-1:1]};
                    a_next   = a_reg >> 1;
                    b_next   = b_reg >> 1;
                end
                ALU_MUL:
                begin
                    // Shift-and-add, multiplier bits taken from the bottom.
                    if (b_reg[0])
                    begin
                        acc_next = acc_reg + a_reg;
                    end
                    a_next = a_reg << 1;
                    b_next = b_reg >> 1;
                end
                ALU_DIV, ALU_MOD:
                begin
                    // Restoring division: quotient bits enter the dividend register.
                    if (!rem_diff[DATA_W])
                    begin
                        acc_next = rem_diff[DATA_W-1:0];
                        a_next   = {a_reg[DATA_W-2:0], 1'b1};
                    end
                    else
                    begin
                        acc_next = rem_shift[DATA_W-1:0];
                        a_next   = {a_reg[DATA_W-2:0], 1'b0};
                    end
                end
                ALU_SHL:
                begin
                    if (cnt_reg < b_reg[CNT_W-1:0])
                    begin
                        a_next = a_reg << 1;
                    end
                end
                ALU_SHR:
                begin
                    if (cnt_reg < b_reg[CNT_W-1:0])
                    begin
                        a_next = a_reg >> 1;
                    end
                end
                default:
                begin
                    a_next = a_reg;
                end
            endcase
            cnt_next = cnt_reg + 1'b1;
            if (cnt_reg == CNT_W'(DATA_W - 1))
            begin
                busy_next = 1'b0;
                fin_next  = 1'b1;
            end
        end
    end

    // Final selection, including the divide by zero and wide shift cases.
    always_comb
    begin
        unique case (op_reg)
            ALU_PASS:                            result = b_reg;
            ALU_ADD, ALU_SUB, ALU_MUL,
            ALU_AND, ALU_OR, ALU_XOR:            result = acc_reg;
            ALU_SHL, ALU_SHR:                    result = shift_big ? '0 : a_reg;
            ALU_DIV:                             result = b_zero ? '1 : a_reg;
            ALU_MOD:                             result = b_zero ? '1 : acc_reg;
            default:                             result = '0;
        endcase
    end

    assign done = fin_reg;

    // Control state.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            fin_reg  <= 1'b0;
            cnt_reg  <= '0;
            op_reg   <= ALU_ZERO;
        end
        else
        begin
            busy_reg <= busy_next;
            fin_reg  <= fin_next;
            cnt_reg  <= cnt_next;
            op_reg   <= op_next;
        end
    end

    // Operand shift registers.
    always_ff @(posedge clk)
    begin
        a_reg     <= a_next;
        b_reg     <= b_next;
        acc_reg   <= acc_next;
        carry_reg <= carry_next;
    end

endmodule

`default_nettype wire

// ===== rtl/hex_calculator_key_engine.sv =====
// Top level of the hex calculator key engine: key decoding, entry state and output register.
// Depends on hck_pkg and instantiates the bit-serial unit hck_alu.
//
// Usage:
//   Key codes arrive as beats on the s_ channel (s_tdata = key_code). Each key gives
//   exactly one result beat on the m_ channel: m_tdata carries the display value and
//   m_tuser the display_update and alarm flags.
//   The clear key code is written over the cfg_ channel while the engine is idle; the
//   user must ensure this, since cfg_ready is always high. Reset sets the clear key to 27 (escape).
//   Digits, backspace, clear and an operator with no number entered give a valid
//   result through the emit state and the output register. An operator after
//   an entered number runs through the bit-serial arithmetic unit, which walks 32 bit
//   steps, so that result passes the calc state, the emit state and the output register.
//   One key is in work at a time; s_tready is high only while the sequencer is idle, so
//   the next key waits until the last one's result is in the output register.
//   The result sits in an output register; while m_tready is low it holds and the
//   next key may be accepted, but its result waits until the register drains.
//   Reset (rst_n low, asynchronous) clears the entry and first operand, sets the
//   pending operator to equals and marks a new number as starting.
`default_nettype none

module hex_calculator_key_engine (
    input  wire logic        clk,
    input  wire logic        rst_n,
    // Key beats. s_tdata: [7:0] key_code.
    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [7:0]  s_tdata,
    // Result beats. m_tdata: [31:0] display_value.
    output logic             m_tvalid,
    input  wire logic        m_tready,
    output logic [31:0]      m_tdata,
    // m_tuser: [0] display_update, [1] alarm.
    output logic [1:0]       m_tuser,
    // Clear key register write.
    input  wire logic        cfg_valid,
    output logic             cfg_ready,
    input  wire logic [7:0]  cfg_data
);
    import hck_pkg::*;

    state_t            state_reg, state_next;
    logic [DATA_W-1:0] entry_reg, entry_next;
    logic [DATA_W-1:0] first_reg, first_next;
    alu_op_t           pend_reg,  pend_next;
    logic              new_reg,   new_next;
    logic [7:0]        clear_reg;
    logic              upd_reg,   upd_next;
    logic              alarm_reg, alarm_next;
    logic              mvalid_reg, mvalid_next;
    logic [DATA_W-1:0] mdata_reg;
    logic [1:0]        muser_reg;

    logic [7:0]        key;
    logic [DATA_W-1:0] digit_base;
    logic              accept;
    logic              out_free;
    logic              key_is_calc;
    alu_req_t          alu_req;
    logic              alu_done;
    logic [DATA_W-1:0] alu_result;

    assign key      = fold_key(s_tdata);
    assign accept   = s_tvalid && s_tready;
    assign out_free = !mvalid_reg || m_tready;

    // An operator key needs the arithmetic unit only after an entered number.
    assign key_is_calc = (key != KEY_BACKSPACE) && (key != clear_reg) &&
                         !is_hex_key(key) && !new_reg;

    // A starting number begins from zero; the old entry becomes the first operand.
    assign digit_base = new_reg ? '0 : entry_reg;

    hck_alu u_alu (
        .clk    (clk),
        .rst_n  (rst_n),
        .req    (alu_req),
        .opa    (first_reg),
        .opb    (entry_reg),
        .done   (alu_done),
        .result (alu_result)
    );

    // Sequencer next state.
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    state_next = key_is_calc ? ST_CALC : ST_EMIT;
                end
            end
            ST_CALC:
            begin
                if (alu_done)
                begin
                    state_next = ST_EMIT;
                end
            end
            ST_EMIT:
            begin
                if (out_free)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Sequencer outputs and calculator state updates.
    always_comb
    begin
        s_tready     = (state_reg == ST_IDLE);
        alu_req      = '{start: 1'b0, op: pend_reg};
        entry_next   = entry_reg;
        first_next   = first_reg;
        pend_next    = pend_reg;
        new_next     = new_reg;
        upd_next     = upd_reg;
        alarm_next   = alarm_reg;
        mvalid_next  = mvalid_reg && !m_tready;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    upd_next   = 1'b0;
                    alarm_next = 1'b0;
                    priority if (key == KEY_BACKSPACE)
                    begin
                        entry_next = entry_reg >> 4;
                        upd_next   = 1'b1;
                    end
                    else if (key == clear_reg)
                    begin
                        entry_next = '0;
                        upd_next   = 1'b1;
                    end
                    else if (is_hex_key(key))
                    begin
                        if (new_reg)
                        begin
                            first_next = entry_reg;
                        end
                        new_next = 1'b0;
                        // Refuse the digit when its shift would lose the top nibble.
                        if (digit_base[DATA_W-1:DATA_W-4] == 4'd0)
                        begin
                            entry_next = {digit_base[DATA_W-5:0], hex_digit(key)};
                            upd_next   = 1'b1;
                        end
                        else
                        begin
                            entry_next = digit_base;
                            alarm_next = 1'b1;
                        end
                    end
                    else
                    begin
                        if (!new_reg)
                        begin
                            alu_req.start = 1'b1;
                            upd_next      = 1'b1;
                        end
                        new_next  = 1'b1;
                        pend_next = key_to_op(key);
                    end
                end
            end
            ST_CALC:
            begin
                if (alu_done)
                begin
                    entry_next = alu_result;
                end
            end
            ST_EMIT:
            begin
                if (out_free)
                begin
                    mvalid_next = 1'b1;
                end
            end
            default:
            begin
                mvalid_next = mvalid_reg && !m_tready;
            end
        endcase
    end

    // Control and calculator state.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= ST_IDLE;
            entry_reg  <= '0;
            first_reg  <= '0;
            pend_reg   <= ALU_PASS;
            new_reg    <= 1'b1;
            clear_reg  <= KEY_CLEAR_RST;
            mvalid_reg <= 1'b0;
        end
        else
        begin
            state_reg  <= state_next;
            entry_reg  <= entry_next;
            first_reg  <= first_next;
            pend_reg   <= pend_next;
            new_reg    <= new_next;
            mvalid_reg <= mvalid_next;
            if (cfg_valid && cfg_ready)
            begin
                clear_reg <= cfg_data;
            end
        end
    end

    // Flag staging and output payload.
    always_ff @(posedge clk)
    begin
        upd_reg   <= upd_next;
        alarm_reg <= alarm_next;
        if (state_reg == ST_EMIT && out_free)
        begin
            mdata_reg <= entry_reg;
            muser_reg <= {alarm_reg, upd_reg};
        end
    end

    assign cfg_ready = 1'b1;
    assign m_tvalid  = mvalid_reg;
    assign m_tdata   = mdata_reg;
    assign m_tuser   = muser_reg;

endmodule

`default_nettype wire

// ===== rtl/hck_checker.sv =====
// Port-level checks for the hex calculator key engine, bound to its top level.
// Depends only on the top level's ports.
`default_nettype none

module hck_checker (
    input wire logic        clk,
    input wire logic        rst_n,
    input wire logic        s_tvalid,
    input wire logic        s_tready,
    input wire logic        m_tvalid,
    input wire logic        m_tready,
    input wire logic [31:0] m_tdata,
    input wire logic [1:0]  m_tuser
);

    // A stalled result beat holds its value and flags.
    assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
        else $error("result beat changed while stalled");

    // A refused digit never also refreshes the display.
    assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> !(m_tuser[0] && m_tuser[1]))
        else $error("alarm and display update both set");

    // A refused digit means the entry already filled the top nibble.
    assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && m_tuser[1] |-> m_tdata[31:28] != 4'd0)
        else $error("alarm with room left for a digit");

    // Only one key is in work at a time.
    assert property (@(posedge clk) disable iff (!rst_n)
        s_tvalid && s_tready |=> !s_tready)
        else $error("key accepted on consecutive cycles");

endmodule

bind hex_calculator_key_engine hck_checker u_hck_checker (.*);

`default_nettype wire

// ===== verif/hex_calculator_key_engine_tb.sv =====
// Self-checking testbench for the hex calculator key engine: directed key sequences, then
// random keystroke runs under several clear key settings and handshake idling patterns.
// Depends on hck_pkg and the RTL top level hex_calculator_key_engine.

module hex_calculator_key_engine_tb;
    timeunit 1ns;
    timeprecision 1ps;

    import hck_pkg::*;

    localparam int unsigned CYCLE_LIMIT    = 400_000;
    localparam int unsigned IDLE_SETTLE    = 40;
    localparam int unsigned DRAIN_CYCLES   = 50;
    localparam int unsigned HOLDOFF_LEN    = 300;
    localparam int unsigned PRESSURE_KEYS  = 12;
    localparam int unsigned PHASES         = 7;
    localparam int unsigned KEYS_PER_PHASE = 115;
    localparam int unsigned REPORT_LIMIT   = 10;
    localparam logic [31:0] DIGIT_CEILING  = 32'h0FFF_FFFF;
    localparam logic [7:0]  KEY_LOWER_G    = "g";

    // One display beat as the engine reports it.
    typedef struct packed {
        logic [31:0] value;
        logic        update;
        logic        alarm;
    } display_t;

    // One row of the directed key table; typed rows carry their own expectation.
    typedef struct packed {
        logic [7:0]  key;
        logic        typed;
        logic [31:0] value;
        logic        update;
        logic        alarm;
    } key_row_t;

    localparam int unsigned DIRECTED_ROWS = 34;
    localparam key_row_t DIRECTED [DIRECTED_ROWS] = '{
        '{KEY_EQUALS,    1'b1, 32'h0000_0000, 1'b0, 1'b0},
        '{"f",           1'b1, 32'h0000_000F, 1'b1, 1'b0},
        '{"F",           1'b0, 32'h0,         1'b0, 1'b0},
        '{"e",           1'b0, 32'h0,         1'b0, 1'b0},
        '{"E",           1'b0, 32'h0,         1'b0, 1'b0},
        '{"d",           1'b0, 32'h0,         1'b0, 1'b0},
        '{"D",           1'b0, 32'h0,         1'b0, 1'b0},
        '{"c",           1'b0, 32'h0,         1'b0, 1'b0},
        '{"C",           1'b0, 32'h0,         1'b0, 1'b0},
        '{"7",           1'b1, 32'hFFEE_DDCC, 1'b0, 1'b1},
        '{KEY_BACKSPACE, 1'b0, 32'h0,         1'b0, 1'b0},
        '{KEY_CLEAR_RST, 1'b1, 32'h0000_0000, 1'b1, 1'b0},
        '{"9",           1'b0, 32'h0,         1'b0, 1'b0},
        '{KEY_STAR,      1'b0, 32'h0,         1'b0, 1'b0},
        '{"B",           1'b0, 32'h0,         1'b0, 1'b0},
        '{KEY_PLUS,      1'b0, 32'h0,         1'b0, 1'b0},
        '{"3",           1'b0, 32'h0,         1'b0, 1'b0},
        '{KEY_AMP,       1'b0, 32'h0,         1'b0, 1'b0},
        '{"7",           1'b0, 32'h0,         1'b0, 1'b0},
        '{KEY_BAR,       1'b0, 32'h0,         1'b0, 1'b0},
        '{"8",           1'b0, 32'h0,         1'b0, 1'b0},
        '{KEY_CARET,     1'b0, 32'h0,         1'b0, 1'b0},
        '{"A",           1'b0, 32'h0,         1'b0, 1'b0},
        '{KEY_SLASH,     1'b0, 32'h0,         1'b0, 1'b0},
        '{"0",           1'b0, 32'h0,         1'b0, 1'b0},
        '{KEY_PERCENT,   1'b1, 32'hFFFF_FFFF, 1'b1, 1'b0},
        '{"0",           1'b0, 32'h0,         1'b0, 1'b0},
        '{KEY_LESS,      1'b1, 32'hFFFF_FFFF, 1'b1, 1'b0},
        '{KEY_GREATER,   1'b1, 32'hFFFF_FFFF, 1'b0, 1'b0},
        '{"2",           1'b0, 32'h0,         1'b0, 1'b0},
        '{"0",           1'b0, 32'h0,         1'b0, 1'b0},
        '{KEY_LOWER_G,   1'b1, 32'h0000_0000, 1'b1, 1'b0},
        '{"1",           1'b0, 32'h0,         1'b0, 1'b0},
        '{KEY_EQUALS,    1'b1, 32'h0000_0000, 1'b1, 1'b0}
    };

    localparam logic [7:0] OPERATOR_KEYS [11] = '{
        KEY_EQUALS, KEY_PLUS, KEY_MINUS, KEY_STAR, KEY_AMP, KEY_BAR,
        KEY_CARET, KEY_LESS, KEY_GREATER, KEY_SLASH, KEY_PERCENT
    };

    // Clear key per random phase; the last phase draws its own.
    localparam logic [7:0] PHASE_CLEAR_KEYS [PHASES] = '{
        KEY_CLEAR_RST, KEY_BACKSPACE, KEY_LOWER_A, "5", 8'h00, 8'hFF, 8'h00
    };

    logic        clk       = 1'b0;
    logic        rst_n     = 1'b0;
    logic        s_tvalid  = 1'b0;
    logic        s_tready;
    logic [7:0]  s_tdata   = 8'h00;   // [7:0] key_code
    logic        m_tvalid;
    logic        m_tready  = 1'b0;
    logic [31:0] m_tdata;             // [31:0] display_value
    logic [1:0]  m_tuser;             // [0] display_update, [1] alarm
    logic        cfg_valid = 1'b0;
    logic        cfg_ready;
    logic [7:0]  cfg_data  = 8'h00;

    // Shadow of the engine state.
    logic [31:0] entry_q;
    logic [31:0] operand_q;
    logic [7:0]  pending_op_q;
    logic        new_number_q;
    logic [7:0]  clear_q;

    display_t    expected_displays [$];
    display_t    seen_display;
    display_t    wanted_display;

    int unsigned keys_sent     = 0;
    int unsigned beats_checked = 0;
    int unsigned alarms_seen   = 0;
    int unsigned mismatches    = 0;
    int unsigned cycle_count   = 0;
    int unsigned send_idle_pct = 0;
    int unsigned recv_stall_pct = 0;
    int unsigned holdoff_left  = 0;

    hex_calculator_key_engine dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_data  (cfg_data)
    );

    // Clock generation.
    initial
    begin
        forever #6 clk = ~clk;
    end

    // Works out the display beat for one key and advances the shadow state.
    function automatic display_t calc_display(input logic [7:0] raw_key);
        display_t   shown;
        logic [7:0] key;
        logic [3:0] digit;
        shown = '0;
        key   = raw_key;
        if (key >= KEY_LOWER_A && key <= KEY_LOWER_F)
        begin
            key = key - CASE_OFFSET;
        end
        if (key == KEY_BACKSPACE)
        begin
            entry_q      = entry_q >> 4;
            shown.update = 1'b1;
        end
        else if (key == clear_q)
        begin
            entry_q      = '0;
            shown.update = 1'b1;
        end
        else if ((key >= KEY_DIGIT_0 && key <= KEY_DIGIT_9) ||
                 (key >= KEY_UPPER_A && key <= KEY_UPPER_F))
        begin
            digit = (key <= KEY_DIGIT_9) ? 4'(key - KEY_DIGIT_0)
                                         : 4'(key - KEY_UPPER_A + 8'd10);
            if (new_number_q)
            begin
                operand_q = entry_q;
                entry_q   = '0;
            end
            new_number_q = 1'b0;
            if (entry_q <= DIGIT_CEILING)
            begin
                entry_q      = {entry_q[27:0], digit};
                shown.update = 1'b1;
            end
            else
            begin
                shown.alarm = 1'b1;
            end
        end
        else
        begin
            // An operator only computes when a number has been entered since the last one.
            if (!new_number_q)
            begin
                case (pending_op_q)
                    KEY_EQUALS:  entry_q = entry_q;
                    KEY_PLUS:    entry_q = operand_q + entry_q;
                    KEY_MINUS:   entry_q = operand_q - entry_q;
                    KEY_STAR:    entry_q = operand_q * entry_q;
                    KEY_AMP:     entry_q = operand_q & entry_q;
                    KEY_BAR:     entry_q = operand_q | entry_q;
                    KEY_CARET:   entry_q = operand_q ^ entry_q;
                    KEY_LESS:    entry_q = (entry_q < 32) ? operand_q << entry_q[4:0] : '0;
                    KEY_GREATER: entry_q = (entry_q < 32) ? operand_q >> entry_q[4:0] : '0;
                    KEY_SLASH:   entry_q = (entry_q != 0) ? operand_q / entry_q : '1;
                    KEY_PERCENT: entry_q = (entry_q != 0) ? operand_q % entry_q : '1;
                    default:     entry_q = '0;
                endcase
                shown.update = 1'b1;
            end
            new_number_q = 1'b1;
            pending_op_q = key;
        end
        shown.value = entry_q;
        return shown;
    endfunction

    // A random hex digit key, in either case for letters.
    function automatic logic [7:0] random_hex_key();
        int unsigned d;
        d = $urandom_range(15);
        if (d < 10)
        begin
            return KEY_DIGIT_0 + 8'(d);
        end
        return (($urandom_range(1) == 0) ? KEY_UPPER_A : KEY_LOWER_A) + 8'(d - 10);
    endfunction

    // Offers one key beat, after an optional random gap, and predicts its display beat.
    task automatic send_key(input logic [7:0] key, output display_t predicted);
        while ($urandom_range(99) < send_idle_pct)
        begin
            s_tvalid <= 1'b0;
            @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= key;
        @(posedge clk);
        while (!s_tready)
        begin
            @(posedge clk);
        end
        predicted = calc_display(key);
        keys_sent++;
    endtask

    // Sends one key and queues the predicted display beat.
    task automatic press_key(input logic [7:0] key);
        display_t predicted;
        send_key(key, predicted);
        expected_displays.push_back(predicted);
    endtask

    // Writes the clear key once the engine has drained and settled.
    task automatic write_clear_key(input logic [7:0] code);
        s_tvalid <= 1'b0;
        while (expected_displays.size() != 0)
        begin
            @(posedge clk);
        end
        repeat (IDLE_SETTLE) @(posedge clk);
        cfg_valid <= 1'b1;
        cfg_data  <= code;
        @(posedge clk);
        while (!cfg_ready)
        begin
            @(posedge clk);
        end
        clear_q    = code;
        cfg_valid <= 1'b0;
    endtask

    // Receiver: random stalls, or a long counted hold-off when one is requested.
    always @(posedge clk)
    begin
        if (holdoff_left > 0)
        begin
            m_tready     <= 1'b0;
            holdoff_left <= holdoff_left - 1;
        end
        else
        begin
            m_tready <= ($urandom_range(99) >= recv_stall_pct);
        end
    end

    // Result checker: every display beat against the oldest expectation.
    always @(posedge clk)
    begin
        if (rst_n && m_tvalid && m_tready)
        begin
            seen_display.value  = m_tdata;
            seen_display.update = m_tuser[0];
            seen_display.alarm  = m_tuser[1];
            beats_checked++;
            if (seen_display.alarm === 1'b1)
            begin
                alarms_seen++;
            end
            if (expected_displays.size() == 0)
            begin
                if (mismatches < REPORT_LIMIT)
                begin
                    $display("[%0t] unexpected display beat: value %h update %b alarm %b",
                             $realtime, seen_display.value, seen_display.update,
                             seen_display.alarm);
                end
                mismatches++;
            end
            else
            begin
                wanted_display = expected_displays.pop_front();
                if (seen_display.value !== wanted_display.value ||
                    seen_display.update !== wanted_display.update ||
                    seen_display.alarm !== wanted_display.alarm)
                begin
                    if (mismatches < REPORT_LIMIT)
                    begin
                        $display("[%0t] display mismatch: expected value %h update %b alarm %b,%s",
                                 $realtime, wanted_display.value, wanted_display.update,
                                 wanted_display.alarm, "");
                        $display("    got value %h update %b alarm %b",
                                 seen_display.value, seen_display.update,
                                 seen_display.alarm);
                    end
                    mismatches++;
                end
            end
        end
    end

    // Watchdog on the total run length.
    initial
    begin
        while (cycle_count < CYCLE_LIMIT)
        begin
            @(posedge clk);
            cycle_count++;
        end
        $display("Timeout after %0d cycles", cycle_count);
        $display("Testbench completed WITH ERRORS");
        $finish;
    end

    // Stimulus: reset, the directed table, then random phases.
    initial
    begin
        display_t    predicted;
        int unsigned phase_start;
        int unsigned pick;
        int unsigned digits;
        logic [7:0]  key;

        rst_n <= 1'b0;
        repeat (9) @(posedge clk);
        rst_n        <= 1'b1;
        entry_q      = '0;
        operand_q    = '0;
        pending_op_q = KEY_EQUALS;
        new_number_q = 1'b1;
        clear_q      = KEY_CLEAR_RST;
        @(posedge clk);

        // Directed table with the reset clear key and no idling.
        for (int i = 0; i < DIRECTED_ROWS; i++)
        begin
            send_key(DIRECTED[i].key, predicted);
            if (DIRECTED[i].typed)
            begin
                predicted.value  = DIRECTED[i].value;
                predicted.update = DIRECTED[i].update;
                predicted.alarm  = DIRECTED[i].alarm;
            end
            expected_displays.push_back(predicted);
        end

        // Random phases, each with its own clear key and idling pattern.
        for (int phase = 0; phase < PHASES; phase++)
        begin
            key = (phase == PHASES - 1) ? 8'($urandom_range(255)) : PHASE_CLEAR_KEYS[phase];
            write_clear_key(key);
            phase_start = keys_sent;

            // Long receiver hold-off while keys keep coming, so the engine backs up.
            if (phase == 1)
            begin
                send_idle_pct  = 0;
                recv_stall_pct = 0;
                holdoff_left   = HOLDOFF_LEN;
                repeat (PRESSURE_KEYS)
                begin
                    press_key(($urandom_range(2) == 0) ? OPERATOR_KEYS[$urandom_range(10)]
                                                       : random_hex_key());
                end
            end

            case (phase % 4)
                0:       begin send_idle_pct = 0;  recv_stall_pct = 0;  end
                1:       begin send_idle_pct = 47; recv_stall_pct = 0;  end
                2:       begin send_idle_pct = 0;  recv_stall_pct = 47; end
                default: begin send_idle_pct = 10; recv_stall_pct = 10; end
            endcase

            while (keys_sent - phase_start < KEYS_PER_PHASE)
            begin
                pick = $urandom_range(99);
                if (pick < 75)
                begin
                    // Mostly a number followed by an operator; now and then a long one.
                    digits = ($urandom_range(9) == 0) ? $urandom_range(10, 1)
                                                      : $urandom_range(3, 1);
                    repeat (digits)
                    begin
                        press_key(random_hex_key());
                    end
                    key = ($urandom_range(9) == 0) ? 8'($urandom_range(255))
                                                   : OPERATOR_KEYS[$urandom_range(10)];
                end
                else if (pick < 85)
                begin
                    key = KEY_BACKSPACE;
                end
                else if (pick < 90)
                begin
                    key = clear_q;
                end
                else
                begin
                    key = 8'($urandom_range(255));
                end
                press_key(key);
            end
        end

        // Drain and let the engine settle.
        s_tvalid       <= 1'b0;
        recv_stall_pct = 0;
        while (expected_displays.size() != 0)
        begin
            @(posedge clk);
        end
        repeat (DRAIN_CYCLES) @(posedge clk);

        $display("Sent %0d keys over %0d clear key settings; checked %0d display beats, %0d alarms.",
                 keys_sent, PHASES, beats_checked, alarms_seen);
        $display("Mismatches: %0d, cycles used: %0d", mismatches, cycle_count);
        if (mismatches == 0)
        begin
            $display("Testbench completed without errors");
        end
        else
        begin
            $display("Testbench completed WITH ERRORS");
        end
        $finish;
    end

endmodule

// ===== sim.f =====
rtl/hck_pkg.sv
rtl/hck_alu.sv
rtl/hex_calculator_key_engine.sv
rtl/hck_checker.sv
verif/hex_calculator_key_engine_tb.sv
